/* src/dps_pkg.sv */
`default_nettype none

package dps_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int CORDIC_MAX_STEPS = 30;

	// q16.16 angle constants
	localparam int PI_Q      = 205887;
	localparam int TWO_PI_Q  = 411774;
	localparam int HALF_PI_Q = 102944;
	localparam int FOUR_PI_Q = 823548;
	localparam int ONE_Q     = 65536;

	// q2.30 start vector length, pre-scaled by the cordic gain
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

	localparam int MUL_W     = 48;
	localparam int DIV_NUM_W = 64;
	localparam int DIV_DEN_W = 48;

	typedef enum logic [1:0] {
		OP_TICK       = 2'd0,
		OP_SET_VEL    = 2'd1,
		OP_ADD_VEL    = 2'd2,
		OP_LOAD_ANGLE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		CFG_ROD_LENGTH = 2'd0,
		CFG_GRAVITY    = 2'd1,
		CFG_MASS       = 2'd2,
		CFG_DAMPING    = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	// atan(2^-i) in q2.30
	function automatic logic signed [33:0] atan_q30(input logic [4:0] idx);
		logic signed [33:0] r;
		unique case (idx)
			5'd0:  r = 34'sd843314857;
			5'd1:  r = 34'sd497837829;
			5'd2:  r = 34'sd263043837;
			5'd3:  r = 34'sd133525159;
			5'd4:  r = 34'sd67021687;
			5'd5:  r = 34'sd33543516;
			5'd6:  r = 34'sd16775851;
			5'd7:  r = 34'sd8388437;
			5'd8:  r = 34'sd4194283;
			5'd9:  r = 34'sd2097149;
			5'd10: r = 34'sd1048576;
			5'd11: r = 34'sd524288;
			5'd12: r = 34'sd262144;
			5'd13: r = 34'sd131072;
			5'd14: r = 34'sd65536;
			5'd15: r = 34'sd32768;
			5'd16: r = 34'sd16384;
			5'd17: r = 34'sd8192;
			5'd18: r = 34'sd4096;
			5'd19: r = 34'sd2048;
			5'd20: r = 34'sd1024;
			5'd21: r = 34'sd512;
			5'd22: r = 34'sd256;
			5'd23: r = 34'sd128;
			5'd24: r = 34'sd64;
			5'd25: r = 34'sd32;
			5'd26: r = 34'sd16;
			5'd27: r = 34'sd8;
			5'd28: r = 34'sd4;
			5'd29: r = 34'sd2;
			default: r = 34'sd0;
		endcase
		return r;
	endfunction

	// shift right with truncation toward zero
	function automatic logic signed [33:0] shr_tz(input logic signed [33:0] v,
		input logic [4:0] sh);
		logic [33:0] m;
		m = v[33] ? 34'(-v) : 34'(v);
		m = m >> sh;
		return v[33] ? -$signed(m) : $signed(m);
	endfunction

	function automatic logic signed [17:0] clamp_unit(input logic signed [33:0] v);
		logic signed [17:0] r;
		if (v > 34'sd65536)
			r = 18'sd65536;
		else if (v < -34'sd65536)
			r = -18'sd65536;
		else
			r = v[17:0];
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
		logic signed [31:0] r;
		if (v > 35'sd2147483647)
			r = 32'sh7fffffff;
		else if (v < -35'sd2147483648)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

	// one correction by two pi toward [-pi, pi]
	function automatic logic signed [22:0] wrap_once(input logic signed [22:0] a);
		logic signed [22:0] r;
		if (a > 23'sd205887)
			r = a - 23'sd411774;
		else if (a < -23'sd205887)
			r = a + 23'sd411774;
		else
			r = a;
		return r;
	endfunction

endpackage

`default_nettype wire

/* src/dps_cordic.sv */
`default_nettype none

module dps_cordic #(
	parameter int STEPS = dps_pkg::CORDIC_STEPS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [18:0]  angle,
	output logic signed [17:0]  sin_val,
	output logic signed [17:0]  cos_val,
	output dps_pkg::unit_stat_t stat
);
	import dps_pkg::*;

	localparam int N  = (STEPS > CORDIC_MAX_STEPS) ? CORDIC_MAX_STEPS : STEPS;
	localparam int CW = $clog2(N + 1);

	logic signed [33:0] x_q, y_q, z_q;
	logic               flip_q, busy_q, fin_q, done_q;
	logic [CW-1:0]      cnt_q;
	logic signed [17:0] sin_q, cos_q;

	logic signed [18:0] a_f;
	logic               flip_d;
	logic signed [33:0] z0, dx, dy, at;
	logic [4:0]         idx;
	logic signed [17:0] xs, ys;

	// fold into [-pi/2, pi/2]
	always_comb begin
		if (angle > 19'sd102944) begin
			a_f    = angle - 19'sd205887;
			flip_d = 1'b1;
		end else if (angle < -19'sd102944) begin
			a_f    = angle + 19'sd205887;
			flip_d = 1'b1;
		end else begin
			a_f    = angle;
			flip_d = 1'b0;
		end
		z0  = 34'(a_f) * 34'sd16384;
		idx = 5'(cnt_q);
		dx  = shr_tz(y_q, idx);
		dy  = shr_tz(x_q, idx);
		at  = atan_q30(idx);
		xs  = clamp_unit(shr_tz(x_q, 5'd14));
		ys  = clamp_unit(shr_tz(y_q, 5'd14));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			fin_q  <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(N - 1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
			if (fin_q)
				done_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= CORDIC_GAIN;
			y_q    <= '0;
			z_q    <= z0;
			flip_q <= flip_d;
		end else if (busy_q) begin
			if (!z_q[33]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
		if (fin_q) begin
			sin_q <= flip_q ? -ys : ys;
			cos_q <= flip_q ? -xs : xs;
		end
	end

	assign sin_val   = sin_q;
	assign cos_val   = cos_q;
	assign stat.busy = busy_q | fin_q;
	assign stat.done = done_q;

endmodule

`default_nettype wire

/* src/dps_divider.sv */
`default_nettype none

module dps_divider (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic [dps_pkg::DIV_NUM_W-1:0]         dividend,
	input  logic [dps_pkg::DIV_DEN_W-1:0]         divisor,
	output logic [dps_pkg::DIV_NUM_W-1:0]         quotient,
	output logic [dps_pkg::DIV_DEN_W-1:0]         remainder,
	output dps_pkg::unit_stat_t                   stat
);
	import dps_pkg::*;

	localparam int CW = $clog2(DIV_NUM_W + 1);

	logic [DIV_NUM_W-1:0] quot_q;
	logic [DIV_DEN_W-1:0] rem_q, den_q;
	logic [CW-1:0]        cnt_q;
	logic                 busy_q, done_q;
	logic [DIV_DEN_W:0]   trial;
	logic                 fits;

	// restoring division, one quotient bit a cycle
	always_comb begin
		trial = {rem_q, quot_q[DIV_NUM_W-1]};
		fits  = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DIV_NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			den_q  <= divisor;
		end else if (busy_q) begin
			rem_q  <= fits ? DIV_DEN_W'(trial - {1'b0, den_q}) : trial[DIV_DEN_W-1:0];
			quot_q <= {quot_q[DIV_NUM_W-2:0], fits};
		end
	end

	assign quotient  = quot_q;
	assign remainder = rem_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

`default_nettype wire

/* src/dps_multiplier.sv */
`default_nettype none

module dps_multiplier (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [dps_pkg::MUL_W-1:0]     a,
	input  logic [dps_pkg::MUL_W-1:0]     b,
	output logic [2*dps_pkg::MUL_W-1:0]   product,
	output dps_pkg::unit_stat_t           stat
);
	import dps_pkg::*;

	localparam int CW = $clog2(MUL_W + 1);

	logic [MUL_W-1:0] a_q, hi_q, lo_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q, done_q;
	logic [MUL_W:0]   sum;

	// shift-add, one multiplier bit a cycle
	assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(MUL_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= a;
			hi_q <= '0;
			lo_q <= b;
		end else if (busy_q) begin
			hi_q <= sum[MUL_W:1];
			lo_q <= {sum[0], lo_q[MUL_W-1:1]};
		end
	end

	assign product   = {hi_q, lo_q};
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

`default_nettype wire

/* src/damped_pendulum_step_unit.sv */
// Damped pendulum integrator in signed q16.16. Each input transaction carries an
// opcode: a tick advances velocity and angle by one Euler step with gravity and
// damping, the others set or add to the velocity or load the angle. Every input
// transaction yields exactly one output transaction with the wrapped angle, the
// velocity, both energies and the bob offsets, all from the state after the
// operation. The block works on one item at a time and drops s_axis_tready until
// the result has been taken. All arithmetic runs through three shared iterative
// units: a shift-add multiplier, a restoring divider and a cordic rotator. A
// tick takes about 4 products, 2 quotients and 1 rotation for the step and 8
// products and 1 rotation for the outputs; set and add velocity take only the
// output part, and an angle load outside [-pi, pi] adds one quotient to it.
// Configuration writes are always taken (cfg_ready is high) and must only come
// while the block is idle.
`default_nettype none

module damped_pendulum_step_unit #(
	parameter int CORDIC_STEPS = dps_pkg::CORDIC_STEPS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	// input stream
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [63:0]  s_axis_tdata,  // operand_value[31:0], speed_factor[62:32], zero
	input  logic [1:0]   s_axis_tuser,  // opcode[1:0]
	// result stream
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// angle_out[18:0], velocity_out[50:19], kinetic_energy[81:51],
	// potential_energy[113:82], x_offset[145:114], y_offset[177:146], zero
	output logic [183:0] m_axis_tdata,
	// register writes
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [30:0]  cfg_data
);
	import dps_pkg::*;

	typedef enum logic [19:0] {
		ST_IDLE    = 20'h00001,
		ST_T_CORD  = 20'h00002,
		ST_T_DGL   = 20'h00004,
		ST_T_M1    = 20'h00008,
		ST_T_M2    = 20'h00010,
		ST_T_M3    = 20'h00020,
		ST_T_DACC  = 20'h00040,
		ST_T_M4    = 20'h00080,
		ST_WRAP    = 20'h00100,
		ST_P_START = 20'h00200,
		ST_P_CORD  = 20'h00400,
		ST_P_MVL   = 20'h00800,
		ST_P_MSQ   = 20'h01000,
		ST_P_MKE   = 20'h02000,
		ST_P_MMG   = 20'h04000,
		ST_P_MLC   = 20'h08000,
		ST_P_MPE   = 20'h10000,
		ST_P_MX    = 20'h20000,
		ST_P_MY    = 20'h40000,
		ST_OUT     = 20'h80000
	} state_t;

	state_t state_q, state_d;

	// configuration and pendulum state
	logic [30:0]        rod_length_q, gravity_q, mass_q, damping_q;
	logic signed [18:0] angle_q;
	logic signed [31:0] velocity_q;

	// scratch registers of the sequencer
	logic [30:0]        sf_q;
	logic               wrap_hi_q;
	logic signed [17:0] sin_q, cos_q;
	logic [46:0]        gl_q;
	logic signed [49:0] num_q;
	logic               vl_big_q;
	logic [45:0]        mg_q;
	logic [32:0]        lc_q;
	logic [30:0]        ke_q;
	logic [31:0]        pe_q, x_q, y_q;

	// shared unit hookup
	logic                     cor_start;
	logic signed [17:0]       cor_sin, cor_cos;
	unit_stat_t               cor_stat, div_stat, mul_stat;
	logic                     div_start;
	logic [DIV_NUM_W-1:0]     div_num, div_quot;
	logic [DIV_DEN_W-1:0]     div_den, div_rem;
	logic                     mul_start;
	logic [MUL_W-1:0]         mul_a, mul_b;
	logic [2*MUL_W-1:0]       mp;

	logic               accept;
	op_t                op_in;
	logic signed [31:0] operand_in;
	logic [30:0]        sf_in;
	logic [30:0]        len_eff, mass_eff;
	logic [16:0]        s_mag, c_mag;
	logic [31:0]        v_mag;
	logic signed [31:0] vel_add;
	logic               ld_hi, ld_lo;
	logic [31:0]        ld_t;
	logic signed [18:0] ld_res;
	logic [46:0]        t1, t2;
	logic [45:0]        den_eff;
	logic [47:0]        num_mag;
	logic [32:0]        qcap;
	logic signed [33:0] acc;
	logic signed [31:0] vel_tick;
	logic [31:0]        vt_mag;
	logic [19:0]        step_c;
	logic signed [22:0] step_s, ang_sum, ang_w;
	logic [46:0]        vl;
	logic [17:0]        one_minus_c;
	logic [31:0]        xm, ym;

	assign accept     = s_axis_tvalid && s_axis_tready;
	assign op_in      = op_t'(s_axis_tuser);
	assign operand_in = s_axis_tdata[31:0];
	assign sf_in      = s_axis_tdata[62:32];

	// a zero length or mass acts as one lsb
	assign len_eff  = (rod_length_q == '0) ? 31'd1 : rod_length_q;
	assign mass_eff = (mass_q == '0) ? 31'd1 : mass_q;

	always_comb begin
		s_mag   = sin_q[17] ? 17'(-sin_q) : 17'(sin_q);
		c_mag   = cos_q[17] ? 17'(-cos_q) : 17'(cos_q);
		v_mag   = velocity_q[31] ? 32'(-velocity_q) : 32'(velocity_q);
		vel_add = sat32(35'(velocity_q) + 35'(operand_in));

		// angle load: remainder by two pi brings it back into range
		ld_hi  = operand_in > 32'sd205887;
		ld_lo  = operand_in < -32'sd205887;
		ld_t   = ld_hi ? 32'(operand_in - 32'sd205888) : 32'(-32'sd205888 - operand_in);
		ld_res = 19'(wrap_hi_q ? $signed({1'b0, div_rem[18:0]}) - 20'sd205886
			: 20'sd205886 - $signed({1'b0, div_rem[18:0]}));

		// tick terms
		t1      = mp[62:16];
		t2      = mp[62:16];
		den_eff = (mp[61:16] == '0) ? 46'd1 : mp[61:16];
		num_mag = num_q[49] ? 48'(-num_q) : num_q[47:0];

		// acceleration magnitude capped at 2^32
		qcap = ((div_quot[63:33] != '0) || (div_quot[32] && (div_quot[31:0] != '0)))
			? 33'h1_0000_0000 : div_quot[32:0];
		acc      = num_q[49] ? -$signed({1'b0, qcap}) : $signed({1'b0, qcap});
		vel_tick = sat32(35'(velocity_q) + 35'(acc));
		vt_mag   = vel_tick[31] ? 32'(-vel_tick) : 32'(vel_tick);

		// angle step clamped to four pi, then at most two corrections
		step_c  = (mp[62:16] > 47'(FOUR_PI_Q)) ? 20'(FOUR_PI_Q) : mp[35:16];
		step_s  = velocity_q[31] ? -$signed({3'b0, step_c}) : $signed({3'b0, step_c});
		ang_sum = 23'(angle_q) + step_s;
		ang_w   = wrap_once(wrap_once(ang_sum));

		// output terms
		vl          = mp[62:16];
		one_minus_c = 18'(19'sd65536 - 19'(cos_q));
		xm          = {1'b0, mp[46:16]};
		ym          = {1'b0, mp[46:16]};
	end

	// sequencer: each compute state waits on one unit, then issues the next operation
	always_comb begin
		state_d   = state_q;
		cor_start = 1'b0;
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		mul_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (op_in)
						OP_TICK: begin
							cor_start = 1'b1;
							state_d   = ST_T_CORD;
						end
						OP_SET_VEL, OP_ADD_VEL: state_d = ST_P_START;
						OP_LOAD_ANGLE: begin
							if (ld_hi || ld_lo) begin
								div_start = 1'b1;
								div_num   = {32'b0, ld_t};
								div_den   = DIV_DEN_W'(TWO_PI_Q);
								state_d   = ST_WRAP;
							end else begin
								state_d = ST_P_START;
							end
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_T_CORD: begin
				if (cor_stat.done) begin
					// g/L
					div_start = 1'b1;
					div_num   = {17'b0, gravity_q, 16'b0};
					div_den   = {17'b0, len_eff};
					state_d   = ST_T_DGL;
				end
			end
			ST_T_DGL: begin
				if (div_stat.done) begin
					mul_start = 1'b1;
					mul_a     = {1'b0, div_quot[46:0]};
					mul_b     = {31'b0, s_mag};
					state_d   = ST_T_M1;
				end
			end
			ST_T_M1: begin
				if (mul_stat.done) begin
					mul_start = 1'b1;
					mul_a     = {17'b0, damping_q};
					mul_b     = {16'b0, v_mag};
					state_d   = ST_T_M2;
				end
			end
			ST_T_M2: begin
				if (mul_stat.done) begin
					mul_start = 1'b1;
					mul_a     = {17'b0, mass_eff};
					mul_b     = {17'b0, len_eff};
					state_d   = ST_T_M3;
				end
			end
			ST_T_M3: begin
				if (mul_stat.done) begin
					div_start = 1'b1;
					div_num   = {num_mag, 16'b0};
					div_den   = {2'b0, den_eff};
					state_d   = ST_T_DACC;
				end
			end
			ST_T_DACC: begin
				if (div_stat.done) begin
					mul_start = 1'b1;
					mul_a     = {16'b0, vt_mag};
					mul_b     = {17'b0, sf_q};
					state_d   = ST_T_M4;
				end
			end
			ST_T_M4: begin
				if (mul_stat.done)
					state_d = ST_P_START;
			end
			ST_WRAP: begin
				if (div_stat.done)
					state_d = ST_P_START;
			end
			ST_P_START: begin
				cor_start = 1'b1;
				state_d   = ST_P_CORD;
			end
			ST_P_CORD: begin
				if (cor_stat.done) begin
					mul_start = 1'b1;
					mul_a     = {16'b0, v_mag};
					mul_b     = {17'b0, len_eff};
					state_d   = ST_P_MVL;
				end
			end
			ST_P_MVL: begin
				if (mul_stat.done) begin
					mul_start = 1'b1;
					mul_a     = {16'b0, vl[31:0]};
					mul_b     = {16'b0, vl[31:0]};
					state_d   = ST_P_MSQ;
				end
			end
			ST_P_MSQ: begin
				if (mul_stat.done) begin
					mul_start = 1'b1;
					mul_a     = {17'b0, mass_eff};
					mul_b     = mp[63:16];
					state_d   = ST_P_MKE;
				end
			end
			ST_P_MKE: begin
				if (mul_stat.done) begin
					mul_start = 1'b1;
					mul_a     = {17'b0, mass_eff};
					mul_b     = {17'b0, gravity_q};
					state_d   = ST_P_MMG;
				end
			end
			ST_P_MMG: begin
				if (mul_stat.done) begin
					mul_start = 1'b1;
					mul_a     = {17'b0, len_eff};
					mul_b     = {30'b0, one_minus_c};
					state_d   = ST_P_MLC;
				end
			end
			ST_P_MLC: begin
				if (mul_stat.done) begin
					mul_start = 1'b1;
					mul_a     = {2'b0, mg_q};
					mul_b     = {15'b0, mp[48:16]};
					state_d   = ST_P_MPE;
				end
			end
			ST_P_MPE: begin
				if (mul_stat.done) begin
					mul_start = 1'b1;
					mul_a     = {17'b0, len_eff};
					mul_b     = {31'b0, s_mag};
					state_d   = ST_P_MX;
				end
			end
			ST_P_MX: begin
				if (mul_stat.done) begin
					mul_start = 1'b1;
					mul_a     = {17'b0, len_eff};
					mul_b     = {31'b0, c_mag};
					state_d   = ST_P_MY;
				end
			end
			ST_P_MY: begin
				if (mul_stat.done)
					state_d = ST_OUT;
			end
			ST_OUT: begin
				if (m_axis_tready)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control, configuration and pendulum state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			rod_length_q <= 31'd6553600;
			gravity_q    <= 31'd642908;
			mass_q       <= 31'd65536;
			damping_q    <= '0;
			angle_q      <= '0;
			velocity_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_ROD_LENGTH: rod_length_q <= cfg_data;
					CFG_GRAVITY:    gravity_q    <= cfg_data;
					CFG_MASS:       mass_q       <= cfg_data;
					CFG_DAMPING:    damping_q    <= cfg_data;
					default:        damping_q    <= damping_q;
				endcase
			end
			if (state_q == ST_IDLE && accept) begin
				if (op_in == OP_SET_VEL)
					velocity_q <= operand_in;
				else if (op_in == OP_ADD_VEL)
					velocity_q <= vel_add;
				else if (op_in == OP_LOAD_ANGLE && !(ld_hi || ld_lo))
					angle_q <= operand_in[18:0];
			end
			if (state_q == ST_T_DACC && div_stat.done)
				velocity_q <= vel_tick;
			if (state_q == ST_T_M4 && mul_stat.done)
				angle_q <= ang_w[18:0];
			if (state_q == ST_WRAP && div_stat.done)
				angle_q <= ld_res;
		end
	end

	// scratch captures at accept and as each unit finishes
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					sf_q      <= sf_in;
					wrap_hi_q <= ld_hi;
				end
			end
			ST_T_CORD: if (cor_stat.done) sin_q <= cor_sin;
			ST_T_DGL:  if (div_stat.done) gl_q <= div_quot[46:0];
			ST_T_M1: begin
				// num = -(g/L)*sin - damping*velocity
				if (mul_stat.done)
					num_q <= sin_q[17] ? $signed({3'b0, t1}) : -$signed({3'b0, t1});
			end
			ST_T_M2: begin
				if (mul_stat.done)
					num_q <= velocity_q[31] ? num_q + $signed({3'b0, t2})
						: num_q - $signed({3'b0, t2});
			end
			ST_P_CORD: begin
				if (cor_stat.done) begin
					sin_q <= cor_sin;
					cos_q <= cor_cos;
				end
			end
			ST_P_MVL: if (mul_stat.done) vl_big_q <= (vl[46:32] != '0);
			ST_P_MKE: begin
				if (mul_stat.done)
					ke_q <= (vl_big_q || (mp[95:48] != '0)) ? 31'h7fffffff : mp[47:17];
			end
			ST_P_MMG: if (mul_stat.done) mg_q <= mp[61:16];
			ST_P_MLC: if (mul_stat.done) lc_q <= mp[48:16];
			ST_P_MPE: begin
				if (mul_stat.done)
					pe_q <= (mp[95:47] != '0) ? 32'h7fffffff : {1'b0, mp[46:16]};
			end
			ST_P_MX: if (mul_stat.done) x_q <= sin_q[17] ? 32'(-xm) : xm;
			ST_P_MY: if (mul_stat.done) y_q <= cos_q[17] ? 32'(-ym) : ym;
			default: gl_q <= gl_q;
		endcase
	end

	dps_cordic #(
		.STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cor_start),
		.angle   (angle_q),
		.sin_val (cor_sin),
		.cos_val (cor_cos),
		.stat    (cor_stat)
	);

	dps_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_num),
		.divisor   (div_den),
		.quotient  (div_quot),
		.remainder (div_rem),
		.stat      (div_stat)
	);

	dps_multiplier u_multiplier (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (mul_a),
		.b       (mul_b),
		.product (mp),
		.stat    (mul_stat)
	);

	// input taken only with every shared unit at rest
	assign s_axis_tready = (state_q == ST_IDLE) && !cor_stat.busy && !div_stat.busy
		&& !mul_stat.busy;
	assign m_axis_tvalid = (state_q == ST_OUT);
	assign m_axis_tdata  = {6'b0, y_q, x_q, pe_q, ke_q, velocity_q, angle_q};
	assign cfg_ready     = 1'b1;

endmodule

`default_nettype wire

/* src/dps_checker.sv */
`default_nettype none

module dps_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic [63:0]  s_axis_tdata,
	input logic [1:0]   s_axis_tuser,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [183:0] m_axis_tdata,
	input logic         cfg_valid,
	input logic         cfg_ready,
	input logic [1:0]   cfg_index,
	input logic [30:0]  cfg_data
);

	// one item in flight: no input while a result is pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
		else $error("input ready while a result is pending");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input ready right after an accepted transaction");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ($signed(m_axis_tdata[18:0]) <= 19'sd205887)
			&& ($signed(m_axis_tdata[18:0]) >= -19'sd205887))
		else $error("angle outside [-pi, pi]");

	a_pe_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !m_axis_tdata[113])
		else $error("negative potential energy");

endmodule

bind damped_pendulum_step_unit dps_checker u_dps_checker (.*);

`default_nettype wire
